### rtl/core/accel_shake_wake_detector_top_macros.svh
// Assertion macros for the shake and wake detector top level.
// Taken in by the top level only; expects signals clk and rst_n in scope.
`ifndef ACCEL_SHAKE_WAKE_DETECTOR_TOP_MACROS_SVH
`define ACCEL_SHAKE_WAKE_DETECTOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASWD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASWD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/aswd_pkg.sv
// Shared types, constants and helper functions of the shake and wake detector.
// No dependencies; every module of the block imports this package.
package aswd_pkg;

    // Sample history and timing.
    localparam int HISTORY_DEPTH    = 8;
    localparam int SAMPLE_PERIOD_MS = 100;
    localparam int SLOT_W           = $clog2(HISTORY_DEPTH);
    localparam int FILL_W           = $clog2(HISTORY_DEPTH + 1);

    // Stream widths.
    localparam int AXIS_W    = 16;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;
    localparam int RESULT_W  = 19;

    // Speed and weighted difference widths.
    localparam int SPEED_W = 17;
    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
    localparam int W_W = 17;

    // instant / 5 = w * 100 / (5 * period), one constant division done as a
    // reciprocal multiply that is exact for every product below 2**P_W.
    localparam int SCALE_MUL = 100;
    localparam int AVG_DIV = 5;
    localparam int P_W = W_W + 7;
    localparam longint INST_DIV = longint'(AVG_DIV) * longint'(SAMPLE_PERIOD_MS);
    localparam int INST_DIV_W = $clog2(INST_DIV);
    localparam int INST_SHIFT = P_W + INST_DIV_W;
    localparam longint INST_RECIP =
        ((longint'(1) << INST_SHIFT) + INST_DIV - longint'(1)) / INST_DIV;
    localparam int INST5_W = P_W - 2;
    localparam int INST_PROD_W = INST_SHIFT + INST5_W;

    // speed * 4 / 5 as a reciprocal multiply, exact below 2**AVG_SHIFT.
    localparam int AVG_N_W = SPEED_W + 2;
    localparam int AVG_SHIFT = AVG_N_W + 3;
    localparam longint AVG_RECIP =
        ((longint'(1) << AVG_SHIFT) + longint'(AVG_DIV - 1)) / longint'(AVG_DIV);
    localparam int AVG_PROD_W = AVG_SHIFT + SPEED_W;
    localparam int SUM_W = INST5_W + 1;

    // Sensitivity codes and their thresholds.
    localparam logic [1:0] SENS_SOFT   = 2'd0;
    localparam logic [1:0] SENS_NORMAL = 2'd1;
    localparam logic [1:0] SENS_HARD   = 2'd2;
    localparam logic [SPEED_W-1:0] THR_SOFT   = SPEED_W'(80);
    localparam logic [SPEED_W-1:0] THR_NORMAL = SPEED_W'(150);
    localparam logic [SPEED_W-1:0] THR_HARD   = SPEED_W'(250);

    typedef struct packed {
        logic signed [AXIS_W-1:0] z;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] x;
    } sample_t;

    typedef struct packed {
        logic    valid;
        logic    full;
        sample_t newest;
        sample_t oldest;
    } ring_out_t;

    typedef struct packed {
        logic               valid;
        logic               full;
        logic [INST5_W-1:0] inst5;
    } scale_out_t;

    typedef struct packed {
        logic               history_full;
        logic [SPEED_W-1:0] shake_speed;
        logic               wake;
    } result_t;

    // The reserved code falls back to the normal threshold.
    function automatic logic [SPEED_W-1:0] threshold_of(input logic [1:0] sens);
        logic [SPEED_W-1:0] thr;
        unique case (sens)
            SENS_SOFT:   thr = THR_SOFT;
            SENS_NORMAL: thr = THR_NORMAL;
            SENS_HARD:   thr = THR_HARD;
            default:     thr = THR_NORMAL;
        endcase
        return thr;
    endfunction

endpackage

### rtl/core/aswd_ring.sv
// Sample ring of the shake and wake detector: slot and fill counters plus the
// history memory with a registered read port. Depends on aswd_pkg.
module aswd_ring
    import aswd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      accept,
    input  sample_t   sample_in,
    output ring_out_t ring_out
);

    sample_t mem [HISTORY_DEPTH];

    logic [SLOT_W-1:0] newest_reg;
    logic [SLOT_W-1:0] newest_next;
    logic [SLOT_W-1:0] oldest_addr;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              valid_reg;
    logic              full_reg;
    sample_t           rd_data_reg;
    sample_t           sample_reg;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(HISTORY_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = s + 1'b1;
        end
        return r;
    endfunction

    // The oldest sample sits one slot past the slot being written. It never
    // matches the write address, so the read needs no forwarding.
    always_comb
    begin
        newest_next = slot_inc(newest_reg);
        oldest_addr = slot_inc(newest_next);
        fill_next   = (fill_reg == FILL_W'(HISTORY_DEPTH)) ? fill_reg : fill_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_reg <= '0;
            fill_reg   <= '0;
            valid_reg  <= 1'b0;
            full_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                newest_reg <= newest_next;
                fill_reg   <= fill_next;
            end
            if (adv)
            begin
                valid_reg <= accept;
                full_reg  <= (fill_next == FILL_W'(HISTORY_DEPTH));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[newest_next] <= sample_in;
            rd_data_reg      <= mem[oldest_addr];
            sample_reg       <= sample_in;
        end
    end

    assign ring_out.valid  = valid_reg;
    assign ring_out.full   = full_reg;
    assign ring_out.newest = sample_reg;
    assign ring_out.oldest = rd_data_reg;

endmodule

### rtl/core/aswd_scale.sv
// Feed-forward datapath: weighted axis difference, magnitude and scaling to
// the instant speed divided by five, in three register stages. Uses aswd_pkg.
module aswd_scale
    import aswd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  ring_out_t  ring_in,
    output scale_out_t scale_out
);

    logic signed [W_W-1:0] dx;
    logic signed [W_W-1:0] dy;
    logic signed [W_W-1:0] dz;
    logic signed [W_W-1:0] dx4;
    logic signed [W_W-1:0] dy2;
    logic signed [W_W+1:0] w_sum;
    logic        [W_W+1:0] w_mag;
    logic [P_W-1:0]         p_next;
    logic [INST_PROD_W-1:0] inst_prod;

    logic [W_W-1:0]     w_reg;
    logic [P_W-1:0]     p_reg;
    logic [INST5_W-1:0] inst5_reg;
    logic               v2_reg;
    logic               f2_reg;
    logic               v3_reg;
    logic               f3_reg;
    logic               v4_reg;
    logic               f4_reg;

    always_comb
    begin
        dx = {ring_in.newest.x[AXIS_W-1], ring_in.newest.x}
           - {ring_in.oldest.x[AXIS_W-1], ring_in.oldest.x};
        dy = {ring_in.newest.y[AXIS_W-1], ring_in.newest.y}
           - {ring_in.oldest.y[AXIS_W-1], ring_in.oldest.y};
        dz = {ring_in.newest.z[AXIS_W-1], ring_in.newest.z}
           - {ring_in.oldest.z[AXIS_W-1], ring_in.oldest.z};
        // Bias negative values before the shift so the quotient truncates
        // toward zero.
        dx4 = (dx + (dx[W_W-1] ? W_W'(3) : W_W'(0))) >>> 2;
        dy2 = (dy + (dy[W_W-1] ? W_W'(1) : W_W'(0))) >>> 1;
        w_sum = {{2{dz[W_W-1]}}, dz} + {{2{dy2[W_W-1]}}, dy2} + {{2{dx4[W_W-1]}}, dx4};
        w_mag = w_sum[W_W+1] ? (~w_sum + 1'b1) : w_sum;
        p_next = {{(P_W - W_W){1'b0}}, w_reg} * P_W'(SCALE_MUL);
        inst_prod = INST_PROD_W'(p_reg) * INST_PROD_W'(INST_RECIP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            f2_reg <= 1'b0;
            v3_reg <= 1'b0;
            f3_reg <= 1'b0;
            v4_reg <= 1'b0;
            f4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= ring_in.valid;
            f2_reg <= ring_in.full;
            v3_reg <= v2_reg;
            f3_reg <= f2_reg;
            v4_reg <= v3_reg;
            f4_reg <= f3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_reg     <= w_mag[W_W-1:0];
            p_reg     <= p_next;
            inst5_reg <= inst_prod[INST_SHIFT +: INST5_W];
        end
    end

    assign scale_out.valid = v4_reg;
    assign scale_out.full  = f4_reg;
    assign scale_out.inst5 = inst5_reg;

endmodule

### rtl/core/aswd_avg.sv
// Moving average of the shake speed, wake decision and output register.
// Depends on aswd_pkg for widths, reciprocal constants and thresholds.
module aswd_avg
    import aswd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  logic [1:0] sensitivity,
    input  scale_out_t scale_in,
    output logic       res_valid,
    output result_t    res
);

    logic [AVG_N_W-1:0]    avg_n;
    logic [AVG_PROD_W-1:0] avg_prod;
    logic [SPEED_W-1:0]    avg_q;
    logic [SUM_W-1:0]      sum;
    logic [SPEED_W-1:0]    sat;
    logic [SPEED_W-1:0]    speed_next;
    logic [SPEED_W-1:0]    speed_reg;
    logic                  out_valid_reg;
    result_t               res_next;
    result_t               res_reg;

    // New average = instant/5 + speed*4/5, saturated to the speed width.
    always_comb
    begin
        avg_n    = {speed_reg, 2'b00};
        avg_prod = AVG_PROD_W'(avg_n) * AVG_PROD_W'(AVG_RECIP);
        avg_q    = avg_prod[AVG_SHIFT +: SPEED_W];
        sum      = SUM_W'(scale_in.inst5) + SUM_W'(avg_q);
        sat      = (sum > SUM_W'(SPEED_MAX)) ? SPEED_MAX : sum[SPEED_W-1:0];
        speed_next = (scale_in.valid && scale_in.full) ? sat : speed_reg;
        res_next.wake         = scale_in.full && (speed_next > threshold_of(sensitivity));
        res_next.shake_speed  = speed_next;
        res_next.history_full = scale_in.full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            speed_reg     <= speed_next;
            out_valid_reg <= scale_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && scale_in.valid)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

### rtl/core/accel_shake_wake_detector_top.sv
// Top level of the accelerometer shake and wake detector.
// Instantiates aswd_ring, aswd_scale and aswd_avg; uses aswd_pkg and the macro header.
//
// Usage: one x/y/z sample enters per transaction on the s_ channel and one
// result leaves per transaction on the m_ channel, in the same order.
// Samples go into an eight-entry history memory; once it has been filled,
// each new sample is compared with the oldest one still held, and the
// weighted difference is scaled and folded into a running speed average.
// The result carries the averaged speed, a history-full flag and a wake
// flag that compares the speed with the threshold picked by sensitivity.
// Each sample passes the ring, w_reg, p_reg, inst5_reg and the output register.
// Throughput: one sample per clock unless the receiver stalls; the speed
// average update (one reciprocal multiply, add and saturate) is one register loop.
// Reset clears the slot and fill counters, the average and all valid flags
// and sets sensitivity to normal; no clearing pass is needed. When the
// receiver stalls, the whole pipeline holds and s_tready drops until the
// output register is taken. cfg_we writes sensitivity; do so only while idle.
module accel_shake_wake_detector_top
    import aswd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Sample stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [0] wake, [17:1] shake_speed, [18] history_full
    // Sensitivity register.
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_wdata
);

`include "accel_shake_wake_detector_top_macros.svh"

    logic       adv;
    logic       accept;
    logic [1:0] sensitivity_reg;
    ring_out_t  ring_out;
    scale_out_t scale_out;
    result_t    res;

    // The pipeline moves whenever the output register is empty or being taken.
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensitivity_reg <= SENS_NORMAL;
        end
        else if (cfg_we)
        begin
            sensitivity_reg <= cfg_wdata;
        end
    end

    aswd_ring u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .accept    (accept),
        .sample_in (sample_t'(s_tdata)),
        .ring_out  (ring_out)
    );

    aswd_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .ring_in   (ring_out),
        .scale_out (scale_out)
    );

    aswd_avg u_avg (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .sensitivity (sensitivity_reg),
        .scale_in    (scale_out),
        .res_valid   (m_tvalid),
        .res         (res)
    );

    assign m_tdata = {{(M_TDATA_W - RESULT_W){1'b0}}, res};

    // Wake is only raised with a full history and a speed above threshold.
    `ASWD_ASSERT_SAME(a_wake_rule, m_tvalid && res.wake, res.history_full && (res.shake_speed > threshold_of(sensitivity_reg)), "wake without full history or speed above threshold")

    // A stalled output register must block new samples.
    `ASWD_ASSERT_SAME(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready, "input accepted while output stalled")

    // Once the history is full it stays full for every later result.
    `ASWD_ASSERT_NEXT(a_full_sticky, m_tvalid && m_tready && res.history_full, !m_tvalid || res.history_full, "history_full dropped after being set")

endmodule
